// ----- rtl/psb_pkg.sv -----
// Shared types and constants of the 2x pixel scaler.
// No dependencies; the interfaces, front, back and top of the scaler import it.
package psb_pkg;

	localparam int DEF_MAX_WIDTH    = 4096;
	localparam int DEF_CHANNEL_BITS = 16;
	localparam int MAX_HEIGHT       = 4096;
	localparam int ROW_W            = 12;
	localparam int COORD_W          = 13;
	localparam int CHAN_W           = 16;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 13;
	localparam int QUEUE_DEPTH      = 4;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	typedef enum logic [1:0] {
		MODE_DBL_W = 2'd0,
		MODE_HLV_W = 2'd1,
		MODE_DBL_H = 2'd2,
		MODE_HLV_H = 2'd3
	} psb_mode_t;

	// Which results one source pixel produces, in output order:
	// first average, copy, wrap-around average.
	typedef struct packed {
		psb_mode_t mode;
		logic      has_w;
		logic      has_c;
		logic      has_a;
	} psb_ctl_t;

endpackage

// ----- rtl/psb_if.sv -----
// Handshake channels of the 2x pixel scaler: source pixels in, result pixels out.
// Depends on psb_pkg for the field widths.
interface psb_pixel_if
	import psb_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] chan0;
	logic [CHAN_W-1:0] chan1;
	logic [CHAN_W-1:0] chan2;
	logic [CHAN_W-1:0] chan3;

	modport source (output valid, output chan0, output chan1, output chan2, output chan3,
		input ready);
	modport sink (input valid, input chan0, input chan1, input chan2, input chan3,
		output ready);
endinterface

interface psb_result_if
	import psb_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] out_col;
	logic [COORD_W-1:0] out_row;
	logic [CHAN_W-1:0]  out_chan0;
	logic [CHAN_W-1:0]  out_chan1;
	logic [CHAN_W-1:0]  out_chan2;
	logic [CHAN_W-1:0]  out_chan3;
	logic               run_last;

	modport source (output valid, output out_col, output out_row, output out_chan0,
		output out_chan1, output out_chan2, output out_chan3, output run_last,
		input ready);
	modport sink (input valid, input out_col, input out_row, input out_chan0,
		input out_chan1, input out_chan2, input out_chan3, input run_last,
		output ready);
endinterface

// ----- rtl/psb_ram.sv -----
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
module psb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end
endmodule

// ----- rtl/psb_queue.sv -----
// Short FIFO between the front and back parts of the scaler; head is read combinationally.
// No dependencies.
module psb_queue #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       nonempty,
	output logic [$clog2(DEPTH+1)-1:0] level
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [LW-1:0]    level_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				level_q <= level_q + LW'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LW'(1);
			end
		end
	end

	assign rdata    = mem_q[rd_ptr_q];
	assign nonempty = (level_q != '0);
	assign level    = level_q;
endmodule

// ----- rtl/psb_front.sv -----
// Front part of the scaler: configuration, raster counters, line stores, classification.
// Depends on psb_pkg, psb_if and psb_ram.
module psb_front
	import psb_pkg::*;
#(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
	parameter int DEPTH        = QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	psb_pixel_if.sink                         pixel,
	input  logic                              cfg_we,
	input  logic [CFG_IDX_W-1:0]              cfg_idx,
	input  logic [CFG_DATA_W-1:0]             cfg_data,
	input  logic [$clog2(DEPTH+1)-1:0]        q_level,
	output logic                              push,
	output psb_ctl_t                          e_ctl,
	output logic [$clog2(MAX_WIDTH)-1:0]      e_x,
	output logic [ROW_W-1:0]                  e_y,
	output logic [4*CHANNEL_BITS-1:0]         e_cur,
	output logic [4*CHANNEL_BITS-1:0]         e_opa,
	output logic [4*CHANNEL_BITS-1:0]         e_opb
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = 4 * CHANNEL_BITS;
	localparam int EW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
	localparam int LW = $clog2(DEPTH+1);

	psb_mode_t             mode_q;
	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;
	logic [CW-1:0]         col_q;
	logic [ROW_W-1:0]      row_q;
	logic [PW-1:0]         prev_pixel_q;
	logic [PW-1:0]         row_first_q;

	logic                  valid_s1;
	psb_ctl_t              ctl_s1;
	logic [CW-1:0]         x_s1;
	logic [ROW_W-1:0]      y_s1;
	logic [PW-1:0]         cur_s1;
	logic [PW-1:0]         prev_s1;
	logic [PW-1:0]         first_s1;
	logic                  y0_s1;

	logic                  accept;
	logic                  restart;
	logic [PW-1:0]         cur;
	logic [EW-1:0]         w_ext;
	logic [EW-1:0]         w_eff;
	logic [CW-1:0]         w_last;
	logic [CFG_DATA_W-1:0] h_eff;
	logic [ROW_W-1:0]      h_last;
	logic                  last_col;
	logic                  last_row;
	logic                  line_mode;
	psb_ctl_t              ctl;
	logic [PW-1:0]         prev_line_rd;
	logic [PW-1:0]         first_line_rd;

	assign cur = {pixel.chan3[CHANNEL_BITS-1:0], pixel.chan2[CHANNEL_BITS-1:0],
		pixel.chan1[CHANNEL_BITS-1:0], pixel.chan0[CHANNEL_BITS-1:0]};

	// leave one slot for the item already in stage 1
	assign pixel.ready = ((LW+1)'(q_level) + (LW+1)'(valid_s1)) < (LW+1)'(DEPTH);
	assign accept      = pixel.valid && pixel.ready;

	// clamp dimensions: zero reads as one, oversize saturates
	always_comb begin
		w_ext = EW'(width_q);
		if (w_ext == '0) begin
			w_eff = EW'(1);
		end else if (w_ext > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		if (height_q == '0) begin
			h_eff = CFG_DATA_W'(1);
		end else if (height_q > CFG_DATA_W'(MAX_HEIGHT)) begin
			h_eff = CFG_DATA_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	assign w_last    = CW'(w_eff - EW'(1));
	assign h_last    = ROW_W'(h_eff - CFG_DATA_W'(1));
	assign last_col  = (col_q == w_last);
	assign last_row  = (row_q == h_last);
	assign line_mode = (mode_q == MODE_DBL_H) || (mode_q == MODE_HLV_H);

	always_comb begin
		ctl       = '0;
		ctl.mode  = mode_q;
		case (mode_q)
			MODE_DBL_W: begin
				ctl.has_a = (col_q != '0);
				ctl.has_c = 1'b1;
				ctl.has_w = last_col;
			end
			MODE_HLV_W: begin
				ctl.has_a = col_q[0];
			end
			MODE_DBL_H: begin
				ctl.has_a = (row_q != '0);
				ctl.has_c = 1'b1;
				ctl.has_w = last_row;
			end
			MODE_HLV_H: begin
				ctl.has_a = row_q[0];
			end
			default: begin
				ctl.has_a = 1'b0;
			end
		endcase
	end

	assign restart = cfg_we && ((cfg_idx == REG_SCALE_MODE) || (cfg_idx == REG_IMAGE_WIDTH)
		|| (cfg_idx == REG_IMAGE_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_DBL_W;
			width_q  <= CFG_DATA_W'(1);
			height_q <= CFG_DATA_W'(1);
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (cfg_we) begin
				case (cfg_idx)
					REG_SCALE_MODE:   mode_q   <= psb_mode_t'(cfg_data[1:0]);
					REG_IMAGE_WIDTH:  width_q  <= cfg_data;
					REG_IMAGE_HEIGHT: height_q <= cfg_data;
					default:          ;
				endcase
			end
			if (restart) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1   <= ctl;
			x_s1     <= col_q;
			y_s1     <= row_q;
			cur_s1   <= cur;
			prev_s1  <= prev_pixel_q;
			first_s1 <= (col_q == '0) ? cur : row_first_q;
			y0_s1    <= (row_q == '0);
			if (!line_mode) begin
				prev_pixel_q <= cur;
			end
			if ((mode_q == MODE_DBL_W) && (col_q == '0)) begin
				row_first_q <= cur;
			end
		end
	end

	// read-first stores: the read returns the entry from before this item's write
	psb_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_prev_line (
		.clk   (clk),
		.we    (accept && line_mode),
		.waddr (col_q),
		.wdata (cur),
		.raddr (col_q),
		.rdata (prev_line_rd)
	);

	psb_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_first_line (
		.clk   (clk),
		.we    (accept && (mode_q == MODE_DBL_H) && (row_q == '0)),
		.waddr (col_q),
		.wdata (cur),
		.raddr (col_q),
		.rdata (first_line_rd)
	);

	assign push  = valid_s1 && (ctl_s1.has_a || ctl_s1.has_c || ctl_s1.has_w);
	assign e_ctl = ctl_s1;
	assign e_x   = x_s1;
	assign e_y   = y_s1;
	assign e_cur = cur_s1;
	assign e_opa = line_mode ? prev_line_rd : prev_s1;
	// on the first row the wrap partner is the pixel itself
	assign e_opb = line_mode ? (y0_s1 ? cur_s1 : first_line_rd) : first_s1;
endmodule

// ----- rtl/psb_back.sv -----
// Back part of the scaler: walks the results of each queued pixel into the output register.
// Depends on psb_pkg and psb_if.
module psb_back
	import psb_pkg::*;
#(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	output logic                         pop,
	input  psb_ctl_t                     ctl,
	input  logic [$clog2(MAX_WIDTH)-1:0] x,
	input  logic [ROW_W-1:0]             y,
	input  logic [4*CHANNEL_BITS-1:0]    cur,
	input  logic [4*CHANNEL_BITS-1:0]    opa,
	input  logic [4*CHANNEL_BITS-1:0]    opb,
	psb_result_if.source                 result
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int CB = CHANNEL_BITS;
	localparam int PW = 4 * CB;
	localparam int XE = (CW + 1 > COORD_W) ? CW + 1 : COORD_W;

	logic [2:0]         done_q;
	logic               out_valid_q;
	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic [PW-1:0]      pix_q;
	logic               last_q;

	logic [2:0]         rem;
	logic [2:0]         pick;
	logic               is_last;
	logic               emit;
	logic [PW-1:0]      avg_in;
	logic [PW-1:0]      avg;
	logic [XE-1:0]      x_ext;
	logic [XE-1:0]      x_dbl;
	logic [COORD_W-1:0] y_ext;
	logic [COORD_W-1:0] y_dbl;
	logic [COORD_W-1:0] col_n;
	logic [COORD_W-1:0] row_n;
	logic [PW-1:0]      pix_n;

	assign rem     = {ctl.has_w, ctl.has_c, ctl.has_a} & ~done_q;
	assign pick[0] = rem[0];
	assign pick[1] = rem[1] && !rem[0];
	assign pick[2] = rem[2] && !rem[1] && !rem[0];
	assign is_last = ((rem & ~pick) == 3'b000);
	assign emit    = q_valid && (!out_valid_q || result.ready);
	assign pop     = emit && is_last;

	// lane-wise (a + b) >> 1; the wrap average pairs the pixel with its partner
	assign avg_in = pick[0] ? opa : opb;
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			logic [CB:0] s;
			s = {1'b0, avg_in[i*CB +: CB]} + {1'b0, cur[i*CB +: CB]};
			avg[i*CB +: CB] = s[CB:1];
		end
	end

	assign x_ext = XE'(x);
	assign x_dbl = x_ext << 1;
	assign y_ext = COORD_W'(y);
	assign y_dbl = y_ext << 1;

	always_comb begin
		col_n = COORD_W'(x_ext);
		row_n = y_ext;
		pix_n = pick[1] ? cur : avg;
		case (ctl.mode)
			MODE_DBL_W: begin
				if (pick[0]) begin
					col_n = COORD_W'(x_dbl - XE'(1));
				end else if (pick[1]) begin
					col_n = COORD_W'(x_dbl);
				end else begin
					col_n = COORD_W'(x_dbl | XE'(1));
				end
			end
			MODE_HLV_W: begin
				col_n = COORD_W'(x_ext >> 1);
			end
			MODE_DBL_H: begin
				if (pick[0]) begin
					row_n = y_dbl - COORD_W'(1);
				end else if (pick[1]) begin
					row_n = y_dbl;
				end else begin
					row_n = y_dbl | COORD_W'(1);
				end
			end
			MODE_HLV_H: begin
				row_n = y_ext >> 1;
			end
			default: begin
				row_n = y_ext;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				done_q <= is_last ? 3'b000 : (done_q | pick);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			col_q  <= col_n;
			row_q  <= row_n;
			pix_q  <= pix_n;
			last_q <= is_last;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_col   = col_q;
	assign result.out_row   = row_q;
	assign result.out_chan0 = CHAN_W'(pix_q[0*CB +: CB]);
	assign result.out_chan1 = CHAN_W'(pix_q[1*CB +: CB]);
	assign result.out_chan2 = CHAN_W'(pix_q[2*CB +: CB]);
	assign result.out_chan3 = CHAN_W'(pix_q[3*CB +: CB]);
	assign result.run_last  = last_q;
endmodule

// ----- rtl/pixel_scale_by_two_wrap.sv -----
// 2x scaler pass (double/halve width or height) over a raster stream of 4-channel pixels.
// A result passes through stage 1, the queue and the output register after its pixel.
// Throughput while the output is not stalled: one result per cycle through the output register;
// a doubling pixel yields 1 result at the first column or row, 2 in between, 3 at the last
// (2 if width or height is one); halving takes one pixel per cycle, one result per pair.
// Reset: counters cleared, mode double-width, 1x1 image, queue and output empty; no line clear.
module pixel_scale_by_two_wrap
	import psb_pkg::*;
#(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	psb_pixel_if.sink             pixel,
	psb_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = 4 * CHANNEL_BITS;
	// queue entry: control, column, row, pixel and its two average partners
	localparam int QW = $bits(psb_ctl_t) + CW + ROW_W + 3 * PW;
	localparam int LW = $clog2(QUEUE_DEPTH+1);

	logic             push;
	logic             pop;
	logic             q_valid;
	logic [LW-1:0]    q_level;
	logic [QW-1:0]    q_wdata;
	logic [QW-1:0]    q_rdata;

	psb_ctl_t         f_ctl;
	logic [CW-1:0]    f_x;
	logic [ROW_W-1:0] f_y;
	logic [PW-1:0]    f_cur;
	logic [PW-1:0]    f_opa;
	logic [PW-1:0]    f_opb;

	psb_ctl_t         h_ctl;
	logic [CW-1:0]    h_x;
	logic [ROW_W-1:0] h_y;
	logic [PW-1:0]    h_cur;
	logic [PW-1:0]    h_opa;
	logic [PW-1:0]    h_opb;

	// Front: holds configuration and the raster counters, transfers one pixel per cycle
	// while the queue has room, and reads/writes the line stores on the same cycle.
	// Pixels that produce no result (odd trailing column or row, even halving
	// positions) are dropped after stage 1.
	psb_front #(
		.MAX_WIDTH    (MAX_WIDTH),
		.CHANNEL_BITS (CHANNEL_BITS),
		.DEPTH        (QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel    (pixel),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.q_level  (q_level),
		.push     (push),
		.e_ctl    (f_ctl),
		.e_x      (f_x),
		.e_y      (f_y),
		.e_cur    (f_cur),
		.e_opa    (f_opa),
		.e_opb    (f_opb)
	);

	assign q_wdata = {f_ctl, f_x, f_y, f_cur, f_opa, f_opb};

	// Decouple: the front keeps transferring pixels while the back is stalled
	// on the result channel, up to the queue depth.
	psb_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (q_wdata),
		.pop      (pop),
		.rdata    (q_rdata),
		.nonempty (q_valid),
		.level    (q_level)
	);

	assign {h_ctl, h_x, h_y, h_cur, h_opa, h_opb} = q_rdata;

	// Back: advance through the head entry's results one per cycle unless the output stalls,
	// mark the final one with run_last and pop the entry as it goes out.
	psb_back #(
		.MAX_WIDTH    (MAX_WIDTH),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.pop     (pop),
		.ctl     (h_ctl),
		.x       (h_x),
		.y       (h_y),
		.cur     (h_cur),
		.opa     (h_opa),
		.opb     (h_opb),
		.result  (result)
	);
endmodule
